/* design/iee_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iee_pkg
// shared types and constants of the infix expression evaluator
// ----------------------------------------------------------------------------
package iee_pkg;

  localparam int IEE_WIDTH = 32;
  localparam int VALUE_W   = 32;
  localparam int QDEPTH    = 4;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_EQ    = 8'h3D;

  typedef enum logic [2:0] {
    OP_DIGIT,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_EQ
  } iee_op_t;

  typedef struct packed {
    iee_op_t    op;
    logic [3:0] digit;
  } iee_item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } iee_qstat_t;

endpackage
`default_nettype wire

/* design/infix_expression_evaluator_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// infix_expression_evaluator_core
// streaming two-precedence integer calculator over ascii characters
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    ch
//   out      output     out_valid / out_stall  value, div_zero
//
// a digit is handled in ST_IDLE alone, an operator or = also passes ST_APPLY
// a pending * first runs the shift-add multiplier loop in ST_MUL
// a pending / first runs the restoring divider in ST_DIV, one bit a cycle,
// then ST_QFIX, and skips both when the divisor is zero
// the front accepts while the item queue has room, so the back end stalls
// only on a full result register; reset is synchronous and needs no pass
// ----------------------------------------------------------------------------
module infix_expression_evaluator_core #(
  parameter int WIDTH = iee_pkg::IEE_WIDTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [7:0]                       ch,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic signed [iee_pkg::VALUE_W-1:0]    value,
  output logic                                  div_zero
);
  import iee_pkg::*;

  iee_qstat_t qstat;
  iee_item_t  push_item;
  iee_item_t  head;
  logic       push;
  logic       pop;

  iee_front u_front (
    .valid (in_valid),
    .ch    (ch),
    .qstat (qstat),
    .stall (in_stall),
    .push  (push),
    .item  (push_item)
  );

  iee_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  iee_back #(
    .WIDTH (WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_item    (head),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .div_zero  (div_zero)
  );

endmodule
`default_nettype wire

/* design/iee_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iee_front
// accepts characters and turns digits and operators into queue items
// ----------------------------------------------------------------------------
module iee_front (
  input  wire logic             valid,
  input  wire logic [7:0]       ch,
  input  iee_pkg::iee_qstat_t   qstat,
  output logic                  stall,
  output logic                  push,
  output iee_pkg::iee_item_t    item
);
  import iee_pkg::*;

  logic useful;

  always_comb begin
    useful     = 1'b1;
    item.digit = ch[3:0];
    item.op    = OP_DIGIT;
    if (ch inside {[CH_0:CH_9]}) begin
      item.op = OP_DIGIT;
    end else begin
      case (ch)
        CH_PLUS:  item.op = OP_ADD;
        CH_MINUS: item.op = OP_SUB;
        CH_MUL:   item.op = OP_MUL;
        CH_DIV:   item.op = OP_DIV;
        CH_EQ:    item.op = OP_EQ;
        default:  useful  = 1'b0;
      endcase
    end
  end

  assign stall = qstat.full;
  assign push  = valid && !qstat.full && useful;

endmodule
`default_nettype wire

/* design/iee_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iee_queue
// short item queue between front and back
// ----------------------------------------------------------------------------
module iee_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  iee_pkg::iee_item_t    push_item,
  input  wire logic             pop,
  output iee_pkg::iee_item_t    head,
  output iee_pkg::iee_qstat_t   qstat
);
  import iee_pkg::*;

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  iee_item_t       mem [QDEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_pop;

  assign qstat.empty = (count == '0);
  assign qstat.full  = (count == CW'(QDEPTH));
  assign head        = mem[rd_ptr];
  assign do_pop      = pop && !qstat.empty;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !qstat.full)
    else $error("queue push while full");

endmodule
`default_nettype wire

/* design/iee_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iee_back
// executes queued items: digit steps, shift-add multiply, restoring divide
// ----------------------------------------------------------------------------
module iee_back #(
  parameter int WIDTH = iee_pkg::IEE_WIDTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  iee_pkg::iee_item_t                    q_item,
  input  iee_pkg::iee_qstat_t                   qstat,
  output logic                                  pop,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic signed [iee_pkg::VALUE_W-1:0]    value,
  output logic                                  div_zero
);
  import iee_pkg::*;

  localparam int CW = $clog2(WIDTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_QFIX,
    ST_APPLY
  } state_t;

  typedef enum logic [1:0] {
    PM_NONE,
    PM_MUL,
    PM_DIV
  } pmul_t;

  state_t           state;
  iee_op_t          cur_op;
  pmul_t            pmul;
  logic             psign;
  logic             zdiv;
  logic             qneg;
  logic [WIDTH-1:0] sum;
  logic [WIDTH-1:0] term;
  logic [WIDTH-1:0] number;
  logic [WIDTH-1:0] work_a;
  logic [WIDTH-1:0] work_b;
  logic [WIDTH-1:0] work_r;
  logic [CW-1:0]    cnt;

  logic [WIDTH-1:0] num_x10;
  logic [WIDTH-1:0] sum_new;
  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   trial;
  logic             div_bit;
  logic [WIDTH-1:0] rem_next;
  logic             emit;

  always_comb begin
    num_x10  = (number << 3) + (number << 1);
    sum_new  = psign ? (sum - term) : (sum + term);
    shifted  = {work_r, work_a[WIDTH-1]};
    trial    = shifted - {1'b0, work_b};
    div_bit  = !trial[WIDTH];
    rem_next = div_bit ? trial[WIDTH-1:0] : shifted[WIDTH-1:0];
    emit     = (state == ST_APPLY) && (cur_op == OP_EQ) && (!out_valid || !out_stall);
  end

  assign pop = (state == ST_IDLE) && !qstat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cur_op    <= OP_DIGIT;
      pmul      <= PM_NONE;
      psign     <= 1'b0;
      zdiv      <= 1'b0;
      sum       <= '0;
      term      <= '0;
      number    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !emit) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!qstat.empty) begin
            cur_op <= q_item.op;
            if (q_item.op == OP_DIGIT) begin
              number <= num_x10 + WIDTH'(q_item.digit);
            end else begin
              number <= '0;
              case (pmul)
                PM_MUL: begin
                  work_a <= term;
                  work_b <= number;
                  work_r <= '0;
                  state  <= ST_MUL;
                end
                PM_DIV: begin
                  if (number == '0) begin
                    term  <= '0;
                    zdiv  <= 1'b1;
                    state <= ST_APPLY;
                  end else begin
                    work_a <= term[WIDTH-1] ? -term : term;
                    work_b <= number[WIDTH-1] ? -number : number;
                    work_r <= '0;
                    qneg   <= term[WIDTH-1] ^ number[WIDTH-1];
                    cnt    <= CW'(WIDTH - 1);
                    state  <= ST_DIV;
                  end
                end
                default: begin
                  term  <= number;
                  state <= ST_APPLY;
                end
              endcase
            end
          end
        end
        ST_MUL: begin
          if (work_b == '0) begin
            term  <= work_r;
            state <= ST_APPLY;
          end else begin
            if (work_b[0]) begin
              work_r <= work_r + work_a;
            end
            work_a <= work_a << 1;
            work_b <= work_b >> 1;
          end
        end
        ST_DIV: begin
          work_r <= rem_next;
          work_a <= {work_a[WIDTH-2:0], div_bit};
          if (cnt == '0) begin
            state <= ST_QFIX;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        ST_QFIX: begin
          term  <= qneg ? -work_a : work_a;
          state <= ST_APPLY;
        end
        ST_APPLY: begin
          case (cur_op)
            OP_MUL: begin
              pmul  <= PM_MUL;
              state <= ST_IDLE;
            end
            OP_DIV: begin
              pmul  <= PM_DIV;
              state <= ST_IDLE;
            end
            OP_ADD, OP_SUB: begin
              sum   <= sum_new;
              term  <= '0;
              pmul  <= PM_NONE;
              psign <= (cur_op == OP_SUB);
              state <= ST_IDLE;
            end
            OP_EQ: begin
              if (emit) begin
                out_valid <= 1'b1;
                value     <= VALUE_W'($signed(sum_new));
                div_zero  <= zdiv;
                sum       <= '0;
                term      <= '0;
                number    <= '0;
                pmul      <= PM_NONE;
                psign     <= 1'b0;
                zdiv      <= 1'b0;
                state     <= ST_IDLE;
              end
            end
            default: state <= ST_IDLE;
          endcase
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (work_b != '0))
    else $error("divider running with zero divisor");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !pop)
    else $error("item popped while back end busy");

  a_clear_after_eq: assert property (@(posedge clk) disable iff (rst)
    (state == ST_APPLY && cur_op == OP_EQ && (!out_valid || !out_stall))
      |=> (sum == '0 && term == '0 && !zdiv && out_valid))
    else $error("state not cleared after result");

endmodule
`default_nettype wire

/* tb/tb_infix_expression_evaluator_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_infix_expression_evaluator_core
// Feeds the calculator ASCII characters one item at a time and checks every
// result. A short directed part covers the empty expression, a leading
// minus, division by zero, an ignored character and the most negative value
// divided by minus one. Random well-formed expressions follow, mixed with
// noise and broken sequences. Both sides idle and stall at random. A
// scoreboard class predicts value and div_zero for each '=' it sees.
// ----------------------------------------------------------------------------
module tb_infix_expression_evaluator_core;
  import iee_pkg::*;

  localparam int W       = IEE_WIDTH;
  localparam int N_ITEMS = 1450;

  typedef enum logic [1:0] {
    PEND_NONE,
    PEND_MUL,
    PEND_DIV
  } pend_op_t;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic               div_zero;
  } calc_result_t;

  class calc_checker;
    logic [W-1:0]  run_sum;
    logic [W-1:0]  term;
    logic [W-1:0]  number;
    pend_op_t      mul_op;
    logic          minus;
    logic          dz_seen;
    calc_result_t  due_results[$];
    int            errors;
    int            n_used;
    int            n_ignored;
    int            n_results;
    int            n_dz;

    function new();
      clear();
      errors    = 0;
      n_used    = 0;
      n_ignored = 0;
      n_results = 0;
      n_dz      = 0;
    endfunction

    function void clear();
      run_sum = '0;
      term    = '0;
      number  = '0;
      mul_op  = PEND_NONE;
      minus   = 1'b0;
      dz_seen = 1'b0;
    endfunction

    // signed division on magnitudes, truncating toward zero
    function logic [W-1:0] quotient(logic [W-1:0] a, logic [W-1:0] b);
      logic [W-1:0] ma;
      logic [W-1:0] mb;
      logic [W-1:0] q;
      ma = a[W-1] ? -a : a;
      mb = b[W-1] ? -b : b;
      q  = ma / mb;
      return (a[W-1] ^ b[W-1]) ? -q : q;
    endfunction

    function void fold_number();
      case (mul_op)
        PEND_MUL: term = term * number;
        PEND_DIV: begin
          if (number == '0) begin
            term    = '0;
            dz_seen = 1'b1;
          end else begin
            term = quotient(term, number);
          end
        end
        default: term = number;
      endcase
      number = '0;
    endfunction

    function void fold_term();
      if (minus) run_sum = run_sum - term;
      else run_sum = run_sum + term;
      term   = '0;
      mul_op = PEND_NONE;
    endfunction

    function void take_char(logic [7:0] c);
      calc_result_t r;
      if (c >= CH_0 && c <= CH_9) begin
        number = number * W'(10) + W'(c - CH_0);
        n_used++;
      end else begin
        case (c)
          CH_PLUS, CH_MINUS: begin
            fold_number();
            fold_term();
            minus = (c == CH_MINUS);
            n_used++;
          end
          CH_MUL, CH_DIV: begin
            fold_number();
            mul_op = (c == CH_MUL) ? PEND_MUL : PEND_DIV;
            n_used++;
          end
          CH_EQ: begin
            fold_number();
            fold_term();
            r.value    = VALUE_W'($signed(run_sum));
            r.div_zero = dz_seen;
            due_results.push_back(r);
            clear();
            n_used++;
          end
          default: n_ignored++;
        endcase
      end
    endfunction

    function void check_result(logic [VALUE_W-1:0] v, logic d);
      calc_result_t r;
      if (due_results.size() == 0) begin
        $error("unexpected result: value %0d div_zero %0b", $signed(v), d);
        errors++;
        return;
      end
      r = due_results.pop_front();
      n_results++;
      if (r.div_zero) n_dz++;
      if (v !== r.value) begin
        $error("value: expected %0d, actual %0d", $signed(r.value), $signed(v));
        errors++;
      end
      if (d !== r.div_zero) begin
        $error("div_zero: expected %0b, actual %0b", r.div_zero, d);
        errors++;
      end
    endfunction
  endclass

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      in_valid  = 1'b0;
  logic                      in_stall;
  logic [7:0]                ch        = 8'h00;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [VALUE_W-1:0] value;
  logic                      div_zero;

  calc_checker calc;
  bit          calm       = 1'b0;
  int          stall_left = 0;
  int          n_expr     = 0;

  infix_expression_evaluator_core #(
    .WIDTH(W)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .ch       (ch),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .value    (value),
    .div_zero (div_zero)
  );

  always #5 clk = ~clk;

  // result side: check accepted items, stall at random
  always @(posedge clk) begin
    int n;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) calc.check_result(value, div_zero);
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 7);
        stall_left <= n - 1;
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_char(logic [7:0] c);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    ch       <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    calc.take_char(c);
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send_char(s[i]);
  endtask

  task automatic send_digits(int len);
    repeat (len) send_char(CH_0 + 8'($urandom_range(0, 9)));
  endtask

  task automatic send_operand();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      // missing number
    end else if (r < 15) send_char(CH_0);
    else if (r < 20) send_text("4294967295");
    else if (r < 25) send_text("2147483648");
    else if (r < 30) send_digits($urandom_range(11, 12));
    else if (r < 75) send_digits($urandom_range(1, 2));
    else send_digits($urandom_range(1, 10));
  endtask

  task automatic send_expression();
    int terms;
    int r;
    terms = $urandom_range(1, 6);
    if ($urandom_range(0, 9) == 0) send_char(CH_MINUS);
    for (int k = 0; k < terms; k++) begin
      if (k > 0) begin
        r = $urandom_range(0, 3);
        case (r)
          0: send_char(CH_PLUS);
          1: send_char(CH_MINUS);
          2: send_char(CH_MUL);
          default: send_char(CH_DIV);
        endcase
      end
      send_operand();
      if ($urandom_range(0, 19) == 0) send_char(8'($urandom_range(0, 255)));
    end
    // broken sequence of arbitrary bytes
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8)) send_char(8'($urandom_range(0, 255)));
    end
    send_char(CH_EQ);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (calc.due_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    string directed[3];
    directed[0] = "=";
    directed[1] = "-2*3/0+4 =";
    directed[2] = "2147483648/4294967295=";
    calc = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    foreach (directed[i]) send_text(directed[i]);
    while (calc.n_used < N_ITEMS) begin
      if ($urandom_range(0, 7) == 0) calm = !calm;
      if (n_expr % 50 == 49) wait_drained();
      send_expression();
      n_expr++;
    end
    wait_drained();
    repeat (200) @(posedge clk);
    $display("covered %0d random expressions, %0d characters used, %0d ignored",
             n_expr, calc.n_used, calc.n_ignored);
    $display("checked %0d results, %0d with division by zero",
             calc.n_results, calc.n_dz);
    if (calc.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
